@@ sv/b64e_pkg.sv @@
// shared types, constants and the sextet-to-ascii mapping for the base64 encoder
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int unsigned CHAR_W    = 7;
   localparam int unsigned SEXTET_W  = 6;
   localparam int unsigned MAX_CHARS = 4;
   localparam int unsigned IDX_W     = $clog2(MAX_CHARS);
   localparam int unsigned Q_DEPTH   = 2;
   localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_char;
   } rsp_type;

   // one request worth of characters, handed from front to back
   typedef struct packed {
      logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
      logic [IDX_W-1:0]                 last_idx;
      logic                             last;
   } job_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] vx;
      logic [CHAR_W-1:0] ch;
      vx = CHAR_W'(v);
      if (v < 6'd26) begin
         ch = CHAR_UPPER + vx;
      end else if (v < 6'd52) begin
         ch = CHAR_LOWER + vx - 7'd26;
      end else if (v < 6'd62) begin
         ch = CHAR_DIGIT + vx - 7'd52;
      end else if (v == 6'd62) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

@@ sv/b64e_front.sv @@
// front end: accepts raw bytes, tracks group phase and leftover bits,
// and turns each request into a job of one to four characters; uses b64e_pkg
`timescale 1ns / 1ps

module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64e_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output b64e_pkg::job_type push_job
);
   import b64e_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic        take;
   logic [7:0]  b;
   logic        fin;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;
   assign b          = req_data.data_byte;
   assign fin        = req_data.last_byte;

   always_comb begin
      push_job = '0;
      push_job.last = fin;
      phase_in = phase_ff;
      left_in  = left_ff;
      unique case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = sextet_char({left_ff[1:0], b[7:4]});
            if (fin) begin
               push_job.chars[1] = sextet_char({b[3:0], 2'b00});
               push_job.chars[2] = PAD_CHAR;
               push_job.last_idx = IDX_W'(2);
               phase_in = PHASE_FIRST;
               left_in  = '0;
            end else begin
               push_job.last_idx = IDX_W'(0);
               phase_in = PHASE_THIRD;
               left_in  = b[3:0];
            end
         end
         PHASE_THIRD: begin
            push_job.chars[0] = sextet_char({left_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.last_idx = IDX_W'(1);
            phase_in = PHASE_FIRST;
            left_in  = '0;
         end
         // the unused phase code behaves as the start of a group
         default: begin
            push_job.chars[0] = sextet_char(b[7:2]);
            if (fin) begin
               push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_job.chars[2] = PAD_CHAR;
               push_job.chars[3] = PAD_CHAR;
               push_job.last_idx = IDX_W'(3);
               phase_in = PHASE_FIRST;
               left_in  = '0;
            end else begin
               push_job.last_idx = IDX_W'(0);
               phase_in = PHASE_SECOND;
               left_in  = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         left_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

@@ sv/b64e_queue.sv @@
// short job queue between front and back so each side can stall on its own
// uses b64e_pkg for the job type and depth
`timescale 1ns / 1ps

module b64e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  b64e_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop,
   output b64e_pkg::job_type head_job
);
   import b64e_pkg::*;

   job_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign push_ready = (fill_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/b64e_back.sv @@
// back end: walks the characters of the head job one per cycle, while the response stage
// is not stalled, into the registered response stage; uses b64e_pkg
`timescale 1ns / 1ps

module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  b64e_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             load, emit, at_end;

   // output stage can take a new character when empty or being drained
   assign load    = !rsp_valid_ff || rsp_ready;
   assign emit    = load && job_valid;
   assign at_end  = (idx_ff == job.last_idx);
   assign job_pop = emit && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (job_pop) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      rsp_valid_in       = load ? job_valid : rsp_valid_ff;
      rsp_in.out_char    = job.chars[idx_ff];
      rsp_in.last_char   = job.last && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/base64_stream_encoder_unit.sv @@
// Streaming Base64 encoder (standard alphabet, '=' padding). Each request carries one byte
// and a last-byte flag; each response carries one ASCII character, with last_char set on the
// final character of a message. A plain byte yields one or two characters and a last byte up
// to four. The back end emits one character per cycle, while it has a job and the output is
// not stalled, from the head of a two-entry job queue; the front accepts a byte in any cycle
// the queue has room, also while a finished character still waits in the output register.
// top level: ties front, queue and back together; uses b64e_pkg
`timescale 1ns / 1ps

module base64_stream_encoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job, head_job;
   logic    head_valid, head_pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .head_job   (head_job)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/b64e_checker.sv @@
// port-level checks for the base64 encoder and the bind that attaches them
// uses b64e_pkg; bound to base64_stream_encoder_unit
`timescale 1ns / 1ps

module b64e_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input b64e_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   // a stalled response keeps its character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no response is shown right after reset
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a pad that is not the final character is followed at once by another pad
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.out_char == PAD_CHAR && !rsp_data.last_char
      |=> rsp_valid && rsp_data.out_char == PAD_CHAR)
      else $error("pad run broken");

   // every character shown is from the alphabet or a pad
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.out_char >= 7'h41 && rsp_data.out_char <= 7'h5A) ||
         (rsp_data.out_char >= 7'h61 && rsp_data.out_char <= 7'h7A) ||
         (rsp_data.out_char >= 7'h30 && rsp_data.out_char <= 7'h39) ||
         rsp_data.out_char == CHAR_PLUS || rsp_data.out_char == CHAR_SLASH ||
         rsp_data.out_char == PAD_CHAR)
      else $error("character outside alphabet");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
